FILE: rtl/core/occupancy_grid_radius_query_unit_defines.svh
// ---------------------------------------------------------------------------
// occupancy grid radius query unit: assertion macros
// Shared check macros; define NO_ASSERTIONS to compile them away.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RADIUS_QUERY_UNIT_DEFINES_SVH
`define OCCUPANCY_GRID_RADIUS_QUERY_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked outside reset
`define OGRQ_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ogrq check failed: same-cycle implication");

// next-cycle implication, checked outside reset
`define OGRQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ogrq check failed: next-cycle implication");

`else

`define OGRQ_ASSERT_IMPL(label, clk, rst, ante, cons)
`define OGRQ_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/core/ogrq_pkg.sv
// ---------------------------------------------------------------------------
// ogrq_pkg
// Field widths, parameter defaults and operation codes of the grid unit.
// ---------------------------------------------------------------------------
package ogrq_pkg;

  // payload field widths
  localparam int ID_W    = 22;
  localparam int COORD_W = 4;
  localparam int DIST_W  = 9;

  // parameter defaults
  localparam int GRID_SIZE_DEF   = 16;
  localparam int MAX_MATCHES_DEF = 8;

  // operation codes
  typedef enum logic {
    OP_MOVE  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

endpackage

FILE: rtl/core/occupancy_grid_radius_query_unit.sv
// ---------------------------------------------------------------------------
// occupancy_grid_radius_query_unit
// Square grid of occupant ids held in one RAM; moves rewrite two cells,
// radius queries scan the grid and return ids of occupied cells in range.
// ---------------------------------------------------------------------------
//  channel   handshake                 payload
//  -------   -----------------------   ------------------------------------
//  command   start / busy              op, occupant_id, src/dst/center
//                                      coordinates, max_dist_sq
//  result    result_strobe (1 cycle)   match_id, match_valid, truncated, last
//
// A move holds busy in S_MOVE: the source is cleared at the accepting edge
// and the destination written in the next cycle; its beat follows.
// A query holds busy in S_SCAN and S_DONE: one RAM read per cell through
// the single RAM port, then the registered read data and the final beat
// from S_DONE; it ends early once more than MAX_MATCHES hits are seen.
// After reset the RAM is cleared one cell per cycle, all GRID_SIZE*GRID_SIZE
// cells, with busy high. Result beats cannot be stalled by the receiver.
// ---------------------------------------------------------------------------
`include "occupancy_grid_radius_query_unit_defines.svh"

module occupancy_grid_radius_query_unit #(
  parameter int GRID_SIZE   = ogrq_pkg::GRID_SIZE_DEF,
  parameter int MAX_MATCHES = ogrq_pkg::MAX_MATCHES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic                        op,
  input  logic [ogrq_pkg::ID_W-1:0]    occupant_id,
  input  logic [ogrq_pkg::COORD_W-1:0] src_row,
  input  logic [ogrq_pkg::COORD_W-1:0] src_col,
  input  logic [ogrq_pkg::COORD_W-1:0] dst_row,
  input  logic [ogrq_pkg::COORD_W-1:0] dst_col,
  input  logic [ogrq_pkg::COORD_W-1:0] center_row,
  input  logic [ogrq_pkg::COORD_W-1:0] center_col,
  input  logic [ogrq_pkg::DIST_W-1:0]  max_dist_sq,
  output logic                        result_strobe,
  output logic [ogrq_pkg::ID_W-1:0]    match_id,
  output logic                        match_valid,
  output logic                        truncated,
  output logic                        last
);

  import ogrq_pkg::*;

  localparam int CELLS = GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(CELLS);
  localparam int CW    = $clog2(GRID_SIZE);
  localparam int DW    = (CW > COORD_W) ? CW : COORD_W;
  localparam int SQ_W  = 2 * DW;
  localparam int SUM_W = SQ_W + 1;
  localparam int CNT_W = $clog2(MAX_MATCHES + 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOVE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t state;

  // scan / clear position
  logic [AW-1:0] scan_addr;
  logic [CW-1:0] scan_row;
  logic [CW-1:0] scan_col;
  logic          issue_on;

  // latched command fields
  logic [COORD_W-1:0] cen_row;
  logic [COORD_W-1:0] cen_col;
  logic [DIST_W-1:0]  lim;
  logic               mv_ok;
  logic [AW-1:0]      mv_addr;
  logic [ID_W-1:0]    mv_id;

  // read pipeline and pending match
  logic             rd_valid;
  logic             rd_in;
  logic             rd_final;
  logic [ID_W-1:0]  pend;
  logic             pend_valid;
  logic [CNT_W-1:0] cnt;

  // ram port
  logic            ram_we;
  logic [AW-1:0]   ram_addr;
  logic [ID_W-1:0] ram_wdata;
  logic [ID_W-1:0] ram_rdata;

  ogrq_ram #(
    .WIDTH(ID_W),
    .DEPTH(CELLS)
  ) u_cells (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign busy = (state != S_IDLE);

  // move cell indexes and grid bounds
  logic          src_ok;
  logic          dst_ok;
  logic [AW-1:0] src_idx;
  logic [AW-1:0] dst_idx;

  assign src_ok  = (int'(src_row) < GRID_SIZE) && (int'(src_col) < GRID_SIZE);
  assign dst_ok  = (int'(dst_row) < GRID_SIZE) && (int'(dst_col) < GRID_SIZE);
  assign src_idx = AW'(src_row) * AW'(GRID_SIZE) + AW'(src_col);
  assign dst_idx = AW'(dst_row) * AW'(GRID_SIZE) + AW'(dst_col);

  // squared distance of the cell being issued
  logic [DW-1:0]    row_a, row_b, col_a, col_b, row_d, col_d;
  logic [SUM_W-1:0] dist_sq;
  logic             in_range;
  logic             scan_last;
  logic             col_wrap;

  always_comb begin
    row_a    = DW'(scan_row);
    row_b    = DW'(cen_row);
    col_a    = DW'(scan_col);
    col_b    = DW'(cen_col);
    row_d    = (row_a >= row_b) ? (row_a - row_b) : (row_b - row_a);
    col_d    = (col_a >= col_b) ? (col_a - col_b) : (col_b - col_a);
    dist_sq  = SUM_W'(SQ_W'(row_d) * SQ_W'(row_d)) + SUM_W'(SQ_W'(col_d) * SQ_W'(col_d));
    in_range = (dist_sq <= SUM_W'(lim));
  end

  assign scan_last = (scan_addr == AW'(CELLS - 1));
  assign col_wrap  = (scan_col == CW'(GRID_SIZE - 1));

  // hit on the cell whose data arrives now
  logic hit;
  logic trunc_hit;

  assign hit       = rd_valid && rd_in && (ram_rdata != '0);
  assign trunc_hit = hit && pend_valid && (cnt == CNT_W'(MAX_MATCHES));

  // ram port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = scan_addr;
    ram_wdata = '0;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_IDLE: begin
        if (start && (op == OP_MOVE)) begin
          ram_we   = src_ok;
          ram_addr = src_idx;
        end
      end
      S_MOVE: begin
        ram_we    = mv_ok;
        ram_addr  = mv_addr;
        ram_wdata = mv_id;
      end
      default: begin
      end
    endcase
  end

  // control state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      scan_addr     <= '0;
      issue_on      <= 1'b0;
      rd_valid      <= 1'b0;
      pend_valid    <= 1'b0;
      cnt           <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      rd_valid      <= 1'b0;
      case (state)
        S_CLEAR: begin
          scan_addr <= scan_addr + 1'b1;
          if (scan_last) begin
            scan_addr <= '0;
            state     <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            if (op == OP_MOVE) begin
              mv_ok   <= dst_ok;
              mv_addr <= dst_idx;
              mv_id   <= occupant_id;
              state   <= S_MOVE;
            end else begin
              cen_row    <= center_row;
              cen_col    <= center_col;
              lim        <= max_dist_sq;
              scan_addr  <= '0;
              scan_row   <= '0;
              scan_col   <= '0;
              issue_on   <= 1'b1;
              pend_valid <= 1'b0;
              cnt        <= '0;
              state      <= S_SCAN;
            end
          end
        end
        S_MOVE: begin
          result_strobe <= 1'b1;
          match_id      <= '0;
          match_valid   <= 1'b0;
          truncated     <= 1'b0;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        S_SCAN: begin
          // issue one cell read per cycle
          if (issue_on) begin
            rd_valid  <= 1'b1;
            rd_in     <= in_range;
            rd_final  <= scan_last;
            scan_addr <= scan_addr + 1'b1;
            if (col_wrap) begin
              scan_col <= '0;
              scan_row <= scan_row + 1'b1;
            end else begin
              scan_col <= scan_col + 1'b1;
            end
            if (scan_last) begin
              issue_on <= 1'b0;
            end
          end
          // hold one match back so the final beat can carry last
          if (hit) begin
            if (!pend_valid) begin
              pend       <= ram_rdata;
              pend_valid <= 1'b1;
              cnt        <= CNT_W'(1);
            end else if (trunc_hit) begin
              result_strobe <= 1'b1;
              match_id      <= pend;
              match_valid   <= 1'b1;
              truncated     <= 1'b1;
              last          <= 1'b1;
              issue_on      <= 1'b0;
              state         <= S_IDLE;
            end else begin
              result_strobe <= 1'b1;
              match_id      <= pend;
              match_valid   <= 1'b1;
              truncated     <= 1'b0;
              last          <= 1'b0;
              pend          <= ram_rdata;
              cnt           <= cnt + 1'b1;
            end
          end
          if (rd_valid && rd_final && !trunc_hit) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          // final beat: held match, or the empty result
          result_strobe <= 1'b1;
          match_id      <= pend_valid ? pend : '0;
          match_valid   <= pend_valid;
          truncated     <= 1'b0;
          last          <= 1'b1;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // checks
  `OGRQ_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `OGRQ_ASSERT_IMPL(a_empty_is_last, clk, rst, result_strobe && !match_valid, last)
  `OGRQ_ASSERT_IMPL(a_trunc_on_last, clk, rst, result_strobe && truncated, last && match_valid)
  `OGRQ_ASSERT_IMPL(a_cnt_bound, clk, rst, pend_valid, cnt <= CNT_W'(MAX_MATCHES))

endmodule

FILE: rtl/core/ogrq_ram.sv
// ---------------------------------------------------------------------------
// ogrq_ram
// Generic single-port synchronous RAM, read before write, registered read.
// ---------------------------------------------------------------------------
module ogrq_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

FILE: verif/occupancy_grid_radius_query_unit_checker.sv
// ---------------------------------------------------------------------------
// occupancy_grid_radius_query_unit_checker
// Watches the command and result channels of the grid unit. Keeps its own
// copy of the cell store, works out the beats each accepted command must
// produce and compares every result beat with the oldest one still owed.
// ---------------------------------------------------------------------------
module occupancy_grid_radius_query_unit_checker #(
  parameter int GRID_SIZE   = ogrq_pkg::GRID_SIZE_DEF,
  parameter int MAX_MATCHES = ogrq_pkg::MAX_MATCHES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         op,
  input  logic [ogrq_pkg::ID_W-1:0]    occupant_id,
  input  logic [ogrq_pkg::COORD_W-1:0] src_row,
  input  logic [ogrq_pkg::COORD_W-1:0] src_col,
  input  logic [ogrq_pkg::COORD_W-1:0] dst_row,
  input  logic [ogrq_pkg::COORD_W-1:0] dst_col,
  input  logic [ogrq_pkg::COORD_W-1:0] center_row,
  input  logic [ogrq_pkg::COORD_W-1:0] center_col,
  input  logic [ogrq_pkg::DIST_W-1:0]  max_dist_sq,
  input  logic                         result_strobe,
  input  logic [ogrq_pkg::ID_W-1:0]    match_id,
  input  logic                         match_valid,
  input  logic                         truncated,
  input  logic                         last,
  output int                           mismatches,
  output int                           beats_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import ogrq_pkg::*;

  typedef struct packed {
    logic [ID_W-1:0] id;
    logic            found;
    logic            trunc;
    logic            is_last;
  } grid_beat_t;

  localparam grid_beat_t DONE_BEAT = '{id: '0, found: 1'b0, trunc: 1'b0, is_last: 1'b1};

  logic [ID_W-1:0] cell_ids [GRID_SIZE*GRID_SIZE];
  grid_beat_t      owed_beats [$];
  int              fail_count;

  // writes outside the grid are dropped
  function automatic void store_cell(int row, int col, logic [ID_W-1:0] value);
    if (row < GRID_SIZE && col < GRID_SIZE) begin
      cell_ids[row*GRID_SIZE + col] = value;
    end
  endfunction

  function automatic int sq_gap(int a, int b);
    return (a - b) * (a - b);
  endfunction

  // row-major scan, capped at MAX_MATCHES hits, further hits only flag truncation
  function automatic void scan_radius(int crow, int ccol, int limit);
    grid_beat_t hits [$];
    logic       overflow;
    int         n;
    overflow = 1'b0;
    for (int r = 0; r < GRID_SIZE; r++) begin
      for (int c = 0; c < GRID_SIZE; c++) begin
        if (cell_ids[r*GRID_SIZE + c] != '0 &&
            sq_gap(r, crow) + sq_gap(c, ccol) <= limit) begin
          if (hits.size() < MAX_MATCHES) begin
            hits.push_back(grid_beat_t'{id: cell_ids[r*GRID_SIZE + c], found: 1'b1,
                                        trunc: 1'b0, is_last: 1'b0});
          end else begin
            overflow = 1'b1;
          end
        end
      end
    end
    n = hits.size();
    if (n == 0) begin
      owed_beats.push_back(DONE_BEAT);
    end else begin
      hits[n-1].trunc   = overflow;
      hits[n-1].is_last = 1'b1;
      foreach (hits[i]) owed_beats.push_back(hits[i]);
    end
  endfunction

  function automatic void check_field(string what, logic [ID_W-1:0] want,
                                      logic [ID_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h actual %h", $time, what, want, got);
      fail_count++;
    end
  endfunction

  // beat check first, then prediction of any command accepted on this edge
  always @(posedge clk) begin
    grid_beat_t want;
    if (rst) begin
      foreach (cell_ids[i]) cell_ids[i] = '0;
      owed_beats.delete();
      fail_count = 0;
    end else begin
      if (result_strobe) begin
        if (owed_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, actual id %h valid %b trunc %b last %b",
                   $time, match_id, match_valid, truncated, last);
          fail_count++;
        end else begin
          want = owed_beats.pop_front();
          check_field("match_id", want.id, match_id);
          check_field("match_valid", ID_W'(want.found), ID_W'(match_valid));
          check_field("truncated", ID_W'(want.trunc), ID_W'(truncated));
          check_field("last", ID_W'(want.is_last), ID_W'(last));
        end
      end
      if (start && !busy) begin
        if (op_t'(op) == OP_QUERY) begin
          scan_radius(int'(center_row), int'(center_col), int'(max_dist_sq));
        end else begin
          // clear first, so a move onto itself keeps the id
          store_cell(int'(src_row), int'(src_col), '0);
          store_cell(int'(dst_row), int'(dst_col), occupant_id);
          owed_beats.push_back(DONE_BEAT);
        end
      end
    end
    beats_owed <= owed_beats.size();
    mismatches <= fail_count;
  end

endmodule

FILE: verif/tb.sv
// ---------------------------------------------------------------------------
// tb
// Drives moves and radius queries into the grid unit: a directed opening
// over the corner cases, then random traffic with random gaps between
// commands. The checker beside the block does all comparison.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ogrq_pkg::*;

  localparam int RANDOM_CMDS = 207;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  op_t                op;
  logic [ID_W-1:0]    occupant_id;
  logic [COORD_W-1:0] src_row, src_col, dst_row, dst_col;
  logic [COORD_W-1:0] center_row, center_col;
  logic [DIST_W-1:0]  max_dist_sq;
  logic               result_strobe;
  logic [ID_W-1:0]    match_id;
  logic               match_valid, truncated, last;
  int                 mismatches, beats_owed;
  logic               no_idle;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  occupancy_grid_radius_query_unit i_dut (
    .clk, .rst, .start, .busy, .op, .occupant_id,
    .src_row, .src_col, .dst_row, .dst_col,
    .center_row, .center_col, .max_dist_sq,
    .result_strobe, .match_id, .match_valid, .truncated, .last
  );

  occupancy_grid_radius_query_unit_checker i_checker (
    .clk, .rst, .start, .busy, .op, .occupant_id,
    .src_row, .src_col, .dst_row, .dst_col,
    .center_row, .center_col, .max_dist_sq,
    .result_strobe, .match_id, .match_valid, .truncated, .last,
    .mismatches, .beats_owed
  );

  // optional idle gap, then hold the command until busy is low at an edge
  task automatic send_command(op_t kind, logic [ID_W-1:0] id,
                              logic [COORD_W-1:0] sr, logic [COORD_W-1:0] sc,
                              logic [COORD_W-1:0] dr, logic [COORD_W-1:0] dc,
                              logic [COORD_W-1:0] cr, logic [COORD_W-1:0] cc,
                              logic [DIST_W-1:0] radius_sq);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      @(negedge clk) start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    op          = kind;
    occupant_id = id;
    src_row     = sr;
    src_col     = sc;
    dst_row     = dr;
    dst_col     = dc;
    center_row  = cr;
    center_col  = cc;
    max_dist_sq = radius_sq;
    start       = 1'b1;
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  // unused fields of each kind carry random noise
  task automatic move_occupant(logic [ID_W-1:0] id, logic [COORD_W-1:0] sr,
                               logic [COORD_W-1:0] sc, logic [COORD_W-1:0] dr,
                               logic [COORD_W-1:0] dc);
    send_command(OP_MOVE, id, sr, sc, dr, dc, COORD_W'($urandom_range(0, 15)),
                 COORD_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 511)));
  endtask

  task automatic query_radius(logic [COORD_W-1:0] cr, logic [COORD_W-1:0] cc,
                              logic [DIST_W-1:0] radius_sq);
    send_command(OP_QUERY, ID_W'($urandom_range(0, 22'h3FFFFF)),
                 COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)),
                 COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)),
                 cr, cc, radius_sq);
  endtask

  task automatic wait_for_results();
    @(negedge clk) start = 1'b0;
    while (beats_owed != 0) @(negedge clk);
  endtask

  initial begin
    logic [7:0]         placed [$];
    logic [7:0]         src_cell, dst_cell;
    logic [ID_W-1:0]    id;
    logic [DIST_W-1:0]  radius_sq;
    int                 pick;
    rst         = 1'b1;
    start       = 1'b0;
    op          = OP_MOVE;
    occupant_id = '0;
    src_row     = '0;
    src_col     = '0;
    dst_row     = '0;
    dst_col     = '0;
    center_row  = '0;
    center_col  = '0;
    max_dist_sq = '0;
    no_idle     = 1'b0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: empty grid, corners, widest id, move onto itself
    query_radius(4'd0, 4'd0, 9'd511);
    move_occupant(22'h3FFFFF, 4'd15, 4'd15, 4'd0, 4'd0);
    move_occupant(22'h000001, 4'd7, 4'd7, 4'd15, 4'd15);
    move_occupant(22'h2AAAAA, 4'd8, 4'd8, 4'd8, 4'd8);
    move_occupant(22'h155555, 4'd3, 4'd3, 4'd0, 4'd15);
    query_radius(4'd0, 4'd0, 9'd0);
    query_radius(4'd15, 4'd15, 9'd0);
    query_radius(4'd8, 4'd8, 9'd511);
    // move with id zero empties the destination
    move_occupant('0, 4'd5, 4'd5, 4'd0, 4'd15);
    // fill part of row 2 for the truncation cases
    for (int k = 0; k < 10; k++) begin
      move_occupant(ID_W'(k + 100), 4'd14, COORD_W'(k), 4'd2, COORD_W'(k));
    end
    query_radius(4'd2, 4'd5, 9'd25);
    query_radius(4'd15, 4'd0, 9'd511);
    query_radius(4'd2, 4'd4, 9'd1);
    query_radius(4'd10, 4'd10, 9'd0);
    // relocate the cell at the origin onto the row
    move_occupant(22'h0ABCDE, 4'd0, 4'd0, 4'd2, 4'd12);
    query_radius(4'd2, 4'd12, 9'd4);
    wait_for_results();

    // random traffic: moves of placed occupants or fresh arrivals, mixed with radius queries
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if ($urandom_range(0, 15) == 0) no_idle = !no_idle;
      if (n == RANDOM_CMDS / 2) wait_for_results();
      if ($urandom_range(0, 99) < 55) begin
        id       = ($urandom_range(0, 29) == 0) ? '0 : ID_W'($urandom_range(1, 22'h3FFFFF));
        dst_cell = 8'($urandom_range(0, 255));
        if (placed.size() > 0 && $urandom_range(0, 1) == 1) begin
          pick     = $urandom_range(0, placed.size() - 1);
          src_cell = placed[pick];
          placed.delete(pick);
        end else begin
          src_cell = 8'($urandom_range(0, 255));
        end
        if (id != '0) placed.push_back(dst_cell);
        if (placed.size() > 64) void'(placed.pop_front());
        move_occupant(id, src_cell[7:4], src_cell[3:0], dst_cell[7:4], dst_cell[3:0]);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 4)      radius_sq = DIST_W'($urandom_range(0, 4));
        else if (pick < 7) radius_sq = DIST_W'($urandom_range(5, 40));
        else               radius_sq = DIST_W'($urandom_range(0, 511));
        query_radius(COORD_W'($urandom_range(0, 15)), COORD_W'($urandom_range(0, 15)),
                     radius_sq);
      end
    end

    wait_for_results();
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("occupancy_grid_radius_query_unit: match");
    end else begin
      $display("occupancy_grid_radius_query_unit: mismatch");
    end
    $finish;
  end

  // watchdog, well beyond the slowest legal run
  initial begin
    #1000000;
    $display("occupancy_grid_radius_query_unit: mismatch");
    $finish;
  end

endmodule

FILE: occupancy_grid_radius_query_unit.f
+incdir+rtl/core
rtl/core/ogrq_pkg.sv
rtl/core/ogrq_ram.sv
rtl/core/occupancy_grid_radius_query_unit.sv
verif/occupancy_grid_radius_query_unit_checker.sv
verif/tb.sv
